@@ rtl/core/swhsr_pkg.sv @@
// shared types, constants and register map for the single-wire humidity sensor reader
// no dependencies

package swhsr_pkg;

    localparam int DATA_BYTES_DEF    = 5;
    localparam int TOTAL_CHANGES_DEF = 85;
    localparam int QUEUE_DEPTH       = 2;

    localparam int OUT_BYTES   = 5;
    localparam int BITS_W      = 6;
    localparam int TIMER_W     = 16;
    localparam int LEVEL_W     = 8;
    localparam int CHANGE_W    = 7;
    localparam int FIRST_BIT_CHANGE = 4;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [15:0] START_LOW_RST = 16'd18000;
    localparam logic [7:0]  RELEASE_RST   = 8'd40;
    localparam logic [7:0]  THRESHOLD_RST = 8'd16;
    localparam logic [7:0]  TIMEOUT_RST   = 8'd255;

    typedef enum logic [1:0] {
        REG_START_LOW = 2'd0,
        REG_RELEASE   = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_TIMEOUT   = 2'd3
    } reg_index_t;

    typedef enum logic [0:0] {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      level;
    } cmd_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [7:0]  one_threshold;
        logic [7:0]  timeout_count;
    } cfg_t;

    typedef struct packed {
        logic              drive_enable;
        logic              drive_level;
        logic              busy_res;
        logic              done_res;
        logic              timed_out;
        logic [7:0]        humidity_whole;
        logic [7:0]        humidity_fraction;
        logic [7:0]        temperature_whole;
        logic [7:0]        temperature_fraction;
        logic [7:0]        check_byte;
        logic [BITS_W-1:0] bits_received;
    } res_t;

endpackage

@@ rtl/core/swhsr_front.sv @@
// front end: takes requests, classifies them and holds them in a short queue
// depends on swhsr_pkg

module swhsr_front #(
    parameter int QDEPTH = swhsr_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [0] line_level
    input  logic              s_tuser,   // [0] req_type
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output swhsr_pkg::cmd_t   cmd
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    swhsr_pkg::cmd_t entry_reg [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    swhsr_pkg::cmd_t in_cmd;
    logic            push;
    logic            pop;

    always_comb
    begin
        in_cmd.kind  = s_tuser ? swhsr_pkg::CMD_START : swhsr_pkg::CMD_TICK;
        // level only matters on ticks
        in_cmd.level = s_tuser ? 1'b1 : s_tdata[0];
    end

    assign s_tready  = (count_reg != CW'(QDEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

@@ rtl/core/swhsr_back.sv @@
// back end: reading sequencer, bit assembly and result register
// depends on swhsr_pkg

module swhsr_back #(
    parameter int DATA_BYTES    = swhsr_pkg::DATA_BYTES_DEF,
    parameter int TOTAL_CHANGES = swhsr_pkg::TOTAL_CHANGES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  swhsr_pkg::cfg_t  cfg,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  swhsr_pkg::cmd_t  cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output swhsr_pkg::res_t  res
);

    localparam int DW        = 8 * DATA_BYTES;
    localparam int BCW       = $clog2(DW + 1);
    localparam int KW        = BCW - 3;
    localparam int TW        = swhsr_pkg::TIMER_W;
    localparam int LW        = swhsr_pkg::LEVEL_W;
    localparam int XW        = swhsr_pkg::CHANGE_W;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_LOW    = 4'b0010,
        PH_HIGH   = 4'b0100,
        PH_LISTEN = 4'b1000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [TW-1:0]    timer_reg, timer_next;
    logic [LW-1:0]    level_cnt_reg, level_cnt_next;
    logic             prev_level_reg, prev_level_next;
    logic [XW-1:0]    change_reg, change_next;
    logic [BCW-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DW-1:0]    data_reg, data_next;
    logic             timeout_reg, timeout_next;
    logic             done_next;
    logic             res_valid_reg;
    swhsr_pkg::res_t  res_reg, res_next;
    logic             step;
    logic [TW-1:0]    timer_inc;
    logic [LW-1:0]    level_inc;
    logic [XW-1:0]    change_inc;
    logic             take_bit;
    logic             put_en;
    logic             new_bit;
    logic [7:0]       byte_out [swhsr_pkg::OUT_BYTES];

    assign cmd_ready  = !res_valid_reg || res_ready;
    assign step       = cmd_valid && cmd_ready;
    assign timer_inc  = timer_reg + 1'b1;
    assign level_inc  = level_cnt_reg + 1'b1;
    assign change_inc = change_reg + 1'b1;
    assign take_bit   = (change_reg >= XW'(swhsr_pkg::FIRST_BIT_CHANGE)) && !change_reg[0];
    assign put_en     = (bit_cnt_reg < BCW'(DW));
    assign new_bit    = (level_cnt_reg > cfg.one_threshold);

    always_comb
    begin
        phase_next      = phase_reg;
        timer_next      = timer_reg;
        level_cnt_next  = level_cnt_reg;
        prev_level_next = prev_level_reg;
        change_next     = change_reg;
        bit_cnt_next    = bit_cnt_reg;
        data_next       = data_reg;
        timeout_next    = timeout_reg;
        done_next       = 1'b0;
        if (cmd.kind == swhsr_pkg::CMD_START)
        begin
            phase_next      = PH_LOW;
            timer_next      = '0;
            level_cnt_next  = '0;
            prev_level_next = 1'b1;
            change_next     = '0;
            bit_cnt_next    = '0;
            data_next       = '0;
            timeout_next    = 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_LOW:
                begin
                    if (timer_inc == '0 || timer_inc >= cfg.start_low_ticks)
                    begin
                        phase_next = PH_HIGH;
                        timer_next = '0;
                    end
                    else
                    begin
                        timer_next = timer_inc;
                    end
                end
                PH_HIGH:
                begin
                    if (timer_inc >= TW'(cfg.release_ticks))
                    begin
                        phase_next      = PH_LISTEN;
                        timer_next      = '0;
                        level_cnt_next  = '0;
                        prev_level_next = 1'b1;
                    end
                    else
                    begin
                        timer_next = timer_inc;
                    end
                end
                PH_LISTEN:
                begin
                    if (cmd.level == prev_level_reg)
                    begin
                        level_cnt_next = level_inc;
                        if (level_inc >= cfg.timeout_count || level_inc == '0)
                        begin
                            timeout_next = 1'b1;
                            phase_next   = PH_IDLE;
                            done_next    = 1'b1;
                        end
                    end
                    else
                    begin
                        if (take_bit && put_en)
                        begin
                            for (int j = 0; j < DATA_BYTES; j++)
                            begin
                                if (bit_cnt_reg[BCW-1:3] == KW'(j))
                                begin
                                    data_next[8*j +: 8] = {data_reg[8*j +: 7], new_bit};
                                end
                            end
                            bit_cnt_next = bit_cnt_reg + 1'b1;
                        end
                        change_next     = change_inc;
                        level_cnt_next  = '0;
                        prev_level_next = cmd.level;
                        if (change_inc >= XW'(TOTAL_CHANGES))
                        begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // bytes past the configured count read as zero
    for (genvar i = 0; i < swhsr_pkg::OUT_BYTES; i++)
    begin : g_bytes
        if (i < DATA_BYTES)
        begin : g_used
            assign byte_out[i] = data_next[8*i +: 8];
        end
        else
        begin : g_unused
            assign byte_out[i] = 8'd0;
        end
    end

    always_comb
    begin
        res_next.drive_enable         = (phase_next == PH_LOW) || (phase_next == PH_HIGH);
        res_next.drive_level          = (phase_next == PH_HIGH);
        res_next.busy_res             = (phase_next != PH_IDLE);
        res_next.done_res             = done_next;
        res_next.timed_out            = timeout_next;
        res_next.humidity_whole       = byte_out[0];
        res_next.humidity_fraction    = byte_out[1];
        res_next.temperature_whole    = byte_out[2];
        res_next.temperature_fraction = byte_out[3];
        res_next.check_byte           = byte_out[4];
        res_next.bits_received        = swhsr_pkg::BITS_W'(bit_cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            timer_reg      <= '0;
            level_cnt_reg  <= '0;
            prev_level_reg <= 1'b1;
            change_reg     <= '0;
            bit_cnt_reg    <= '0;
            data_reg       <= '0;
            timeout_reg    <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg      <= phase_next;
                timer_reg      <= timer_next;
                level_cnt_reg  <= level_cnt_next;
                prev_level_reg <= prev_level_next;
                change_reg     <= change_next;
                bit_cnt_reg    <= bit_cnt_next;
                data_reg       <= data_next;
                timeout_reg    <= timeout_next;
                res_valid_reg  <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ rtl/core/single_wire_humidity_sensor_reader.sv @@
// Single-wire humidity sensor reader. Each request (a start or a one-microsecond tick with the
// sampled line level) gives exactly one result, showing the drive control, status and the
// received bytes after that request. One request is taken per clock cycle while results are
// accepted on m_tready: the sequencer updates its state and registers the result, and a request
// goes through the front queue and then the result register. While a result waits on
// m_tready the sequencer holds, and the front queue takes requests until it holds two, then
// s_tready drops. Write the registers through the APB port only while no request or result is
// in flight, since a queued request uses the values present when it reaches the sequencer.
// depends on swhsr_pkg, swhsr_front, swhsr_back

module single_wire_humidity_sensor_reader #(
    parameter int DATA_BYTES    = swhsr_pkg::DATA_BYTES_DEF,
    parameter int TOTAL_CHANGES = swhsr_pkg::TOTAL_CHANGES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [swhsr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [swhsr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swhsr_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [0] line_level
    input  logic                             s_tuser,  // [0] req_type
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] drive_enable, [1] drive_level, [2] busy_res, [3] timed_out, [11:4] humidity_whole,
    // [19:12] humidity_fraction, [27:20] temperature_whole, [35:28] temperature_fraction,
    // [43:36] check_byte, [49:44] bits_received
    output logic [55:0]                      m_tdata,
    output logic                             m_tlast   // done_res
);

    swhsr_pkg::cfg_t       cfg_reg, cfg_next;
    swhsr_pkg::reg_index_t reg_sel;
    logic                  wr_en;
    logic                  cmd_valid;
    logic                  cmd_ready;
    swhsr_pkg::cmd_t       cmd;
    logic                  res_valid;
    swhsr_pkg::res_t       res;

    assign pready  = 1'b1;
    assign reg_sel = swhsr_pkg::reg_index_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                swhsr_pkg::REG_START_LOW: cfg_next.start_low_ticks = pwdata[15:0];
                swhsr_pkg::REG_RELEASE:   cfg_next.release_ticks   = pwdata[7:0];
                swhsr_pkg::REG_THRESHOLD: cfg_next.one_threshold   = pwdata[7:0];
                swhsr_pkg::REG_TIMEOUT:   cfg_next.timeout_count   = pwdata[7:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            swhsr_pkg::REG_START_LOW: prdata = {16'd0, cfg_reg.start_low_ticks};
            swhsr_pkg::REG_RELEASE:   prdata = {24'd0, cfg_reg.release_ticks};
            swhsr_pkg::REG_THRESHOLD: prdata = {24'd0, cfg_reg.one_threshold};
            swhsr_pkg::REG_TIMEOUT:   prdata = {24'd0, cfg_reg.timeout_count};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks <= swhsr_pkg::START_LOW_RST;
            cfg_reg.release_ticks   <= swhsr_pkg::RELEASE_RST;
            cfg_reg.one_threshold   <= swhsr_pkg::THRESHOLD_RST;
            cfg_reg.timeout_count   <= swhsr_pkg::TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    swhsr_front #(
        .QDEPTH(swhsr_pkg::QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    swhsr_back #(
        .DATA_BYTES    (DATA_BYTES),
        .TOTAL_CHANGES (TOTAL_CHANGES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tvalid = res_valid;
    assign m_tlast  = res.done_res;
    assign m_tdata  = {6'd0,
                       res.bits_received,
                       res.check_byte,
                       res.temperature_fraction,
                       res.temperature_whole,
                       res.humidity_fraction,
                       res.humidity_whole,
                       res.timed_out,
                       res.busy_res,
                       res.drive_level,
                       res.drive_enable};

endmodule

@@ verif/tb.sv @@
// testbench for single_wire_humidity_sensor_reader: start and tick requests in, readouts out
// readouts are predicted by a scoreboard class and checked field by field
// depends on swhsr_pkg and the reader rtl
`timescale 1ns / 100ps

module tb;

    localparam int N_ITEMS = 700;

    typedef enum logic [1:0] {
        LINE_IDLE   = 2'd0,
        LINE_LOW    = 2'd1,
        LINE_HIGH   = 2'd2,
        LINE_LISTEN = 2'd3
    } line_phase_t;

    typedef enum int {
        END_FULL    = 0,
        END_TIMEOUT = 1,
        END_ABANDON = 2
    } reading_end_t;

    class readout_scoreboard;
        swhsr_pkg::cfg_t   cfg;
        line_phase_t       phase;
        logic [15:0]       phase_timer;
        logic [7:0]        level_ticks;
        logic              last_level;
        logic [6:0]        change_count;
        logic [5:0]        bit_count;
        logic [7:0]        rx_bytes [swhsr_pkg::OUT_BYTES];
        logic              timeout_seen;
        swhsr_pkg::res_t   expected_readouts [$];
        int                checked;
        int                errors;

        function new();
            cfg.start_low_ticks = swhsr_pkg::START_LOW_RST;
            cfg.release_ticks   = swhsr_pkg::RELEASE_RST;
            cfg.one_threshold   = swhsr_pkg::THRESHOLD_RST;
            cfg.timeout_count   = swhsr_pkg::TIMEOUT_RST;
            phase   = LINE_IDLE;
            checked = 0;
            errors  = 0;
            clear_reading();
        endfunction

        function void clear_reading();
            phase_timer  = '0;
            level_ticks  = '0;
            last_level   = 1'b1;
            change_count = '0;
            bit_count    = '0;
            timeout_seen = 1'b0;
            foreach (rx_bytes[i])
                rx_bytes[i] = '0;
        endfunction

        function void set_reg(swhsr_pkg::reg_index_t idx, logic [31:0] value);
            case (idx)
                swhsr_pkg::REG_START_LOW: cfg.start_low_ticks = value[15:0];
                swhsr_pkg::REG_RELEASE:   cfg.release_ticks   = value[7:0];
                swhsr_pkg::REG_THRESHOLD: cfg.one_threshold   = value[7:0];
                swhsr_pkg::REG_TIMEOUT:   cfg.timeout_count   = value[7:0];
                default: ;
            endcase
        endfunction

        function void take_request(swhsr_pkg::cmd_kind_t kind, logic level);
            swhsr_pkg::res_t r;
            logic            finished;
            int              slot;
            finished = 1'b0;
            if (kind == swhsr_pkg::CMD_START)
            begin
                clear_reading();
                phase = LINE_LOW;
            end
            else
            begin
                case (phase)
                    LINE_LOW:
                    begin
                        phase_timer = phase_timer + 16'd1;
                        // a zero length still takes one tick
                        if (phase_timer == 16'd0 || phase_timer >= cfg.start_low_ticks)
                        begin
                            phase       = LINE_HIGH;
                            phase_timer = '0;
                        end
                    end
                    LINE_HIGH:
                    begin
                        phase_timer = phase_timer + 16'd1;
                        if (phase_timer >= {8'd0, cfg.release_ticks})
                        begin
                            phase       = LINE_LISTEN;
                            phase_timer = '0;
                            level_ticks = '0;
                            last_level  = 1'b1;
                        end
                    end
                    LINE_LISTEN:
                    begin
                        if (level == last_level)
                        begin
                            level_ticks = level_ticks + 8'd1;
                            if (level_ticks >= cfg.timeout_count || level_ticks == 8'd0)
                            begin
                                timeout_seen = 1'b1;
                                phase        = LINE_IDLE;
                                finished     = 1'b1;
                            end
                        end
                        else
                        begin
                            if (change_count >= 7'(swhsr_pkg::FIRST_BIT_CHANGE)
                                && !change_count[0])
                            begin
                                slot = int'(bit_count) / 8;
                                // bits past the last byte are dropped
                                if (slot < swhsr_pkg::DATA_BYTES_DEF)
                                begin
                                    rx_bytes[slot] = {rx_bytes[slot][6:0],
                                                      level_ticks > cfg.one_threshold};
                                    bit_count = bit_count + 6'd1;
                                end
                            end
                            change_count = change_count + 7'd1;
                            level_ticks  = '0;
                            last_level   = level;
                            if (change_count >= 7'(swhsr_pkg::TOTAL_CHANGES_DEF))
                            begin
                                phase    = LINE_IDLE;
                                finished = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            r.drive_enable         = (phase == LINE_LOW || phase == LINE_HIGH);
            r.drive_level          = (phase == LINE_HIGH);
            r.busy_res             = (phase != LINE_IDLE);
            r.done_res             = finished;
            r.timed_out            = timeout_seen;
            r.humidity_whole       = rx_bytes[0];
            r.humidity_fraction    = rx_bytes[1];
            r.temperature_whole    = rx_bytes[2];
            r.temperature_fraction = rx_bytes[3];
            r.check_byte           = rx_bytes[4];
            r.bits_received        = bit_count;
            expected_readouts.push_back(r);
        endfunction

        function void check_field(string field, int unsigned want, int unsigned seen);
            if (want != seen)
            begin
                $error("%s: expected %0d, got %0d", field, want, seen);
                errors++;
            end
        endfunction

        function void check_result(swhsr_pkg::res_t got);
            swhsr_pkg::res_t want;
            if (expected_readouts.size() == 0)
            begin
                $error("readout arrived with no request outstanding");
                errors++;
                return;
            end
            want = expected_readouts.pop_front();
            checked++;
            check_field("drive_enable", want.drive_enable, got.drive_enable);
            check_field("drive_level", want.drive_level, got.drive_level);
            check_field("busy_res", want.busy_res, got.busy_res);
            check_field("done_res", want.done_res, got.done_res);
            check_field("timed_out", want.timed_out, got.timed_out);
            check_field("humidity_whole", want.humidity_whole, got.humidity_whole);
            check_field("humidity_fraction", want.humidity_fraction, got.humidity_fraction);
            check_field("temperature_whole", want.temperature_whole, got.temperature_whole);
            check_field("temperature_fraction", want.temperature_fraction,
                        got.temperature_fraction);
            check_field("check_byte", want.check_byte, got.check_byte);
            check_field("bits_received", want.bits_received, got.bits_received);
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n    = 1'b0;
    logic                             psel     = 1'b0;
    logic                             penable  = 1'b0;
    logic                             pwrite   = 1'b0;
    logic [swhsr_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [swhsr_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [swhsr_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [7:0]                       s_tdata  = '0;
    logic                             s_tuser  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [55:0]                      m_tdata;
    logic                             m_tlast;

    readout_scoreboard sb = new();
    int n_requests = 0;
    bit quiet_tx   = 1'b0;
    bit quiet_rx   = 1'b0;

    single_wire_humidity_sensor_reader dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // steady ticks before the next level change, kept below the timeout
    function automatic int pick_hold(int thr, int tmo);
        int cap;
        int hi;
        cap = (tmo == 0) ? 0 : tmo - 1;
        if ($urandom_range(0, 99) == 0)
            return $urandom_range(0, cap);
        if ($urandom_range(0, 1) == 1 && thr < cap)
            return $urandom_range(thr + 1, (thr + 3 < cap) ? thr + 3 : cap);
        hi = (thr < cap) ? thr : cap;
        if (hi > 8)
            return $urandom_range(0, 3);
        return $urandom_range((hi > 2) ? hi - 2 : 0, hi);
    endfunction

    task automatic send_request(input swhsr_pkg::cmd_kind_t kind, input logic level);
        int gap;
        gap = pick_gap(quiet_tx);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, level};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_request(kind, level);
        n_requests++;
        if ($urandom_range(0, 149) == 0)
            quiet_tx = !quiet_tx;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_readouts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input swhsr_pkg::reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic settle_and_configure(input logic [15:0] low, input logic [7:0] rel,
                                        input logic [7:0] thr, input logic [7:0] tmo);
        wait_drained();
        write_reg(swhsr_pkg::REG_START_LOW, {16'd0, low});
        write_reg(swhsr_pkg::REG_RELEASE, {24'd0, rel});
        write_reg(swhsr_pkg::REG_THRESHOLD, {24'd0, thr});
        write_reg(swhsr_pkg::REG_TIMEOUT, {24'd0, tmo});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // one start, the drive phases, then a sensor answer that runs to the end, times out, or is cut
    // short so that the next start abandons it; an abandoned reading may stop during the drive phases
    task automatic run_reading(input reading_end_t ending);
        int   n_low;
        int   n_high;
        int   stop_at;
        int   thr;
        int   tmo;
        int   c;
        logic lvl;
        send_request(swhsr_pkg::CMD_START, 1'($urandom_range(0, 1)));
        n_low = (sb.cfg.start_low_ticks == 16'd0) ? 1 : int'(sb.cfg.start_low_ticks);
        if (ending == END_ABANDON && (n_low > 200 || $urandom_range(0, 2) == 0))
        begin
            repeat ($urandom_range(0, 8))
                send_request(swhsr_pkg::CMD_TICK, 1'($urandom_range(0, 1)));
            return;
        end
        repeat (n_low) send_request(swhsr_pkg::CMD_TICK, 1'($urandom_range(0, 1)));
        n_high = (sb.cfg.release_ticks == 8'd0) ? 1 : int'(sb.cfg.release_ticks);
        repeat (n_high) send_request(swhsr_pkg::CMD_TICK, 1'($urandom_range(0, 1)));
        thr     = int'(sb.cfg.one_threshold);
        tmo     = int'(sb.cfg.timeout_count);
        stop_at = (ending == END_FULL) ? swhsr_pkg::TOTAL_CHANGES_DEF
                                       : $urandom_range(0, swhsr_pkg::TOTAL_CHANGES_DEF - 1);
        lvl = 1'b1;
        for (c = 0; c < stop_at; c++)
        begin
            repeat (pick_hold(thr, tmo)) send_request(swhsr_pkg::CMD_TICK, lvl);
            lvl = !lvl;
            send_request(swhsr_pkg::CMD_TICK, lvl);
        end
        if (ending == END_TIMEOUT)
            repeat ((tmo == 0) ? 1 : tmo) send_request(swhsr_pkg::CMD_TICK, lvl);
    endtask

    initial
    begin : result_sink
        int              stall_left;
        bit              held;
        swhsr_pkg::res_t got;
        stall_left = 0;
        held       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.drive_enable         = m_tdata[0];
                got.drive_level          = m_tdata[1];
                got.busy_res             = m_tdata[2];
                got.timed_out            = m_tdata[3];
                got.humidity_whole       = m_tdata[11:4];
                got.humidity_fraction    = m_tdata[19:12];
                got.temperature_whole    = m_tdata[27:20];
                got.temperature_fraction = m_tdata[35:28];
                got.check_byte           = m_tdata[43:36];
                got.bits_received        = m_tdata[49:44];
                got.done_res             = m_tlast;
                sb.check_result(got);
                // one long hold so the request side backs up
                if (sb.checked == 40 && !held)
                begin
                    held       = 1'b1;
                    stall_left = 300;
                end
                else if (stall_left == 0)
                begin
                    stall_left = pick_gap(quiet_rx);
                end
                if ($urandom_range(0, 149) == 0)
                    quiet_rx = !quiet_rx;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int           n;
        int           i;
        int           thr;
        int           tmo;
        reading_end_t how;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks while idle change nothing
        send_request(swhsr_pkg::CMD_TICK, 1'b0);
        send_request(swhsr_pkg::CMD_TICK, 1'b1);

        // zero-length drive phases, every steady tick times out at one
        settle_and_configure(16'd0, 8'd0, 8'd0, 8'd1);
        run_reading(END_ABANDON);
        run_reading(END_FULL);
        run_reading(END_TIMEOUT);
        send_request(swhsr_pkg::CMD_TICK, 1'b1);

        settle_and_configure(16'd1, 8'd1, 8'd1, 8'd6);
        run_reading(END_FULL);

        // zero timeout count
        settle_and_configure(16'd3, 8'd40, 8'd2, 8'd0);
        run_reading(END_TIMEOUT);

        settle_and_configure(16'd65535, 8'd2, 8'd255, 8'd255);
        run_reading(END_ABANDON);
        run_reading(END_ABANDON);

        while (n_requests < N_ITEMS)
        begin
            thr = $urandom_range(0, 6);
            tmo = ($urandom_range(0, 7) == 0) ? 255 : thr + $urandom_range(1, 8);
            settle_and_configure(16'($urandom_range(0, 12)),
                                 ($urandom_range(0, 9) == 0) ? 8'd255
                                                             : 8'($urandom_range(0, 12)),
                                 8'(thr), 8'(tmo));
            n = $urandom_range(1, 2);
            for (i = 0; i < n && n_requests < N_ITEMS; i++)
            begin
                if (i == n - 1)
                    how = ($urandom_range(0, 2) == 0) ? END_TIMEOUT : END_FULL;
                else
                    how = reading_end_t'($urandom_range(0, 2));
                run_reading(how);
                if (how != END_ABANDON)
                    repeat ($urandom_range(0, 3))
                        send_request(swhsr_pkg::CMD_TICK, 1'($urandom_range(0, 1)));
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.expected_readouts.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : watchdog
        #(50_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/swhsr_pkg.sv
rtl/core/swhsr_front.sv
rtl/core/swhsr_back.sv
rtl/core/single_wire_humidity_sensor_reader.sv
verif/tb.sv
